[src/ltrq_pkg.sv]
// Package: sizes, codes and shared types for the lap-tagged ring queue.
`default_nettype none

package ltrq_pkg;

    // Queue geometry
    localparam int NUM_CELLS    = 16;
    localparam int ELEMENT_BITS = 64;
    localparam int LAP_BITS     = 30;

    // Fixed widths of the transaction fields
    localparam int OP_BITS   = 2;
    localparam int DATA_BITS = 64;

    // Derived sizes, settled at elaboration
    localparam int SLOT_BITS   = $clog2(NUM_CELLS);
    localparam int STATUS_BITS = LAP_BITS + 1;
    localparam int LAPS_RAW    = (2 ** LAP_BITS) / NUM_CELLS;
    localparam int LAP_COUNT   = (LAPS_RAW == 0) ? 1 : LAPS_RAW;

    // Last slot and last lap before wrapping
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(NUM_CELLS - 1);
    localparam logic [LAP_BITS-1:0]  LAST_LAP  = LAP_BITS'(LAP_COUNT - 1);

    // Operation codes; the remaining code is a no-op
    typedef enum logic [OP_BITS-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2
    } op_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_RESPOND
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;   // take the input transaction and start the cell reads
        logic execute;   // evaluate the cell, update state, register the result
    } cmd_t;

endpackage

`default_nettype wire

[src/ltrq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ltrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[src/ltrq_ctrl.sv]
// Controller: sequences capture, lookup and response of one transaction.
`default_nettype none

module ltrq_ctrl
    import ltrq_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.execute = 1'b1;
                state_next  = ST_RESPOND;
            end
            ST_RESPOND: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/ltrq_dpath.sv]
// Datapath: indices, cell status and data stores, result registers.
`default_nettype none

module ltrq_dpath
    import ltrq_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cmd_t                 cmd,
    input  wire logic [OP_BITS-1:0]   s_operation,
    input  wire logic [DATA_BITS-1:0] s_element_data,
    output logic                      m_accepted,
    output logic      [DATA_BITS-1:0] m_head_data
);

    // Indices kept as lap and slot, so no divide is needed
    logic [SLOT_BITS-1:0] tail_slot_reg, tail_slot_next;
    logic [LAP_BITS-1:0]  tail_lap_reg,  tail_lap_next;
    logic [SLOT_BITS-1:0] head_slot_reg, head_slot_next;
    logic [LAP_BITS-1:0]  head_lap_reg,  head_lap_next;

    // Per-cell status valid bits; an invalid cell reads as lap 0, empty
    logic [NUM_CELLS-1:0] valid_reg, valid_next;
    logic                 sel_valid_reg;

    // Captured transaction
    op_t                     op_reg;
    logic [ELEMENT_BITS-1:0] elem_reg;

    // Result registers
    logic                    acc_reg, acc_next;
    logic [ELEMENT_BITS-1:0] data_reg, data_next;

    // Store ports
    logic [SLOT_BITS-1:0]    rd_addr;
    logic [STATUS_BITS-1:0]  st_rdata;
    logic [ELEMENT_BITS-1:0] cd_rdata;
    logic                    st_we, cd_we;
    logic [SLOT_BITS-1:0]    wr_addr;
    logic [STATUS_BITS-1:0]  st_wdata;
    logic [STATUS_BITS-1:0]  status;
    logic [LAP_BITS-1:0]     pop_lap;

    // Push looks at the tail cell, pop and peek at the head cell
    assign rd_addr = (op_t'(s_operation) == OP_PUSH) ? tail_slot_reg : head_slot_reg;

    ltrq_ram #(
        .WIDTH (STATUS_BITS),
        .DEPTH (NUM_CELLS)
    ) u_status_ram (
        .clk   (aclk),
        .we    (st_we),
        .waddr (wr_addr),
        .wdata (st_wdata),
        .re    (cmd.capture),
        .raddr (rd_addr),
        .rdata (st_rdata)
    );

    ltrq_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (NUM_CELLS)
    ) u_data_ram (
        .clk   (aclk),
        .we    (cd_we),
        .waddr (wr_addr),
        .wdata (elem_reg),
        .re    (cmd.capture),
        .raddr (rd_addr),
        .rdata (cd_rdata)
    );

    // Capture the transaction and the valid bit of the cell being read
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg        <= op_t'(s_operation);
            elem_reg      <= s_element_data[ELEMENT_BITS-1:0];
            sel_valid_reg <= valid_reg[rd_addr];
        end
    end

    // Evaluate the cell and work out the state updates
    always_comb begin
        status         = sel_valid_reg ? st_rdata : '0;
        pop_lap        = (head_lap_reg == LAST_LAP) ? '0 : head_lap_reg + 1'b1;
        tail_slot_next = tail_slot_reg;
        tail_lap_next  = tail_lap_reg;
        head_slot_next = head_slot_reg;
        head_lap_next  = head_lap_reg;
        valid_next     = valid_reg;
        acc_next       = 1'b0;
        data_next      = '0;
        st_we          = 1'b0;
        cd_we          = 1'b0;
        wr_addr        = head_slot_reg;
        st_wdata       = {1'b0, pop_lap};
        if (cmd.execute) begin
            unique case (op_reg)
                OP_PUSH: begin
                    wr_addr  = tail_slot_reg;
                    st_wdata = {1'b1, tail_lap_reg};
                    if (status == {1'b0, tail_lap_reg}) begin
                        st_we                 = 1'b1;
                        cd_we                 = 1'b1;
                        valid_next[tail_slot_reg] = 1'b1;
                        acc_next              = 1'b1;
                        if (tail_slot_reg == LAST_SLOT) begin
                            tail_slot_next = '0;
                            tail_lap_next  = (tail_lap_reg == LAST_LAP) ? '0
                                                                        : tail_lap_reg + 1'b1;
                        end else begin
                            tail_slot_next = tail_slot_reg + 1'b1;
                        end
                    end
                end
                OP_POP: begin
                    if (status == {1'b1, head_lap_reg}) begin
                        st_we                 = 1'b1;
                        valid_next[head_slot_reg] = 1'b1;
                        acc_next              = 1'b1;
                        if (head_slot_reg == LAST_SLOT) begin
                            head_slot_next = '0;
                            head_lap_next  = pop_lap;
                        end else begin
                            head_slot_next = head_slot_reg + 1'b1;
                        end
                    end
                end
                OP_PEEK: begin
                    if (status[LAP_BITS]) begin
                        acc_next  = 1'b1;
                        data_next = cd_rdata;
                    end
                end
                default: begin
                    acc_next = 1'b0;
                end
            endcase
        end
    end

    // Control state: indices and valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tail_slot_reg <= '0;
            tail_lap_reg  <= '0;
            head_slot_reg <= '0;
            head_lap_reg  <= '0;
            valid_reg     <= '0;
        end else begin
            tail_slot_reg <= tail_slot_next;
            tail_lap_reg  <= tail_lap_next;
            head_slot_reg <= head_slot_next;
            head_lap_reg  <= head_lap_next;
            valid_reg     <= valid_next;
        end
    end

    // Hold the result until the next execute
    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            acc_reg  <= acc_next;
            data_reg <= data_next;
        end
    end

    assign m_accepted  = acc_reg;
    assign m_head_data = DATA_BITS'(data_reg);

endmodule

`default_nettype wire

[src/lap_tagged_ring_queue.sv]
// Top level of the lap-tagged ring queue: controller plus datapath.
//
//  Channel   Direction  Handshake           Payload
//  s_        in         s_valid / s_ready   s_operation[1:0], s_element_data[63:0]
//  m_        out        m_valid / m_ready   m_accepted, m_head_data[63:0]
//
// One transaction at a time: accept, read the cell status and data stores
// (registered read) in ST_LOOKUP, then show the result in ST_RESPOND.
// Reset clears both indices and every cell's status valid bit at once, so
// no clearing pass is needed. A stalled result holds until taken; no new
// transaction is accepted meanwhile.
`default_nettype none

module lap_tagged_ring_queue
    import ltrq_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [OP_BITS-1:0]   s_operation,
    input  wire logic [DATA_BITS-1:0] s_element_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_accepted,
    output logic      [DATA_BITS-1:0] m_head_data
);

    cmd_t cmd;

    ltrq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    ltrq_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_operation    (s_operation),
        .s_element_data (s_element_data),
        .m_accepted     (m_accepted),
        .m_head_data    (m_head_data)
    );

endmodule

`default_nettype wire

[src/ltrq_checker.sv]
// Port-level checker for the lap-tagged ring queue, bound to the top level.
`default_nettype none

module ltrq_checker
    import ltrq_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic                 m_accepted,
    input wire logic [DATA_BITS-1:0] m_head_data
);

    // Never take a new transaction while a result is pending
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while a result is pending");

    // An accepted transaction yields its result once the lookup state has passed
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> ##2 m_valid)
        else $error("result did not appear after lookup");

    // A refused access carries zero data
    a_zero_on_refuse: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_accepted) |-> (m_head_data == '0))
        else $error("refused access returned non-zero data");

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_accepted)
                                   && $stable(m_head_data)))
        else $error("stalled result changed");

endmodule

bind lap_tagged_ring_queue ltrq_checker u_ltrq_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_accepted  (m_accepted),
    .m_head_data (m_head_data)
);

`default_nettype wire

[tb/lap_tagged_ring_queue_test.sv]
// Testbench for the lap-tagged ring queue: random and directed accesses against a predictor.
`timescale 1ns / 100ps

module lap_tagged_ring_queue_test
    import ltrq_pkg::*;
();

    // The spare operation code changes nothing
    localparam logic [OP_BITS-1:0] OP_NONE = 2'd3;

    // Index range: largest multiple of the cell count within the lap range
    localparam longint unsigned INDEX_RANGE = longint'(LAP_COUNT) * NUM_CELLS;
    localparam logic [STATUS_BITS-1:0] FULL_MARK = STATUS_BITS'(1) << LAP_BITS;
    localparam logic [DATA_BITS-1:0] ELEMENT_MASK =
        {DATA_BITS{1'b1}} >> (DATA_BITS - ELEMENT_BITS);

    localparam int RANDOM_ACCESSES = 400;
    localparam int QUIET_TAIL      = 60;
    localparam int SETTLE_CYCLES   = 8;

    // Shapes of the random runs
    localparam int RUN_FILL    = 0;
    localparam int RUN_DRAIN   = 1;
    localparam int RUN_BALANCE = 2;

    typedef struct {
        logic [OP_BITS-1:0]   op;
        logic [DATA_BITS-1:0] data;
    } queue_access_t;

    typedef struct {
        logic                 accepted;
        logic [DATA_BITS-1:0] head_data;
    } queue_answer_t;

    logic                 aclk;
    logic                 aresetn        = 1'b0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic [OP_BITS-1:0]   s_operation    = OP_NONE;
    logic [DATA_BITS-1:0] s_element_data = '0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic                 m_accepted;
    logic [DATA_BITS-1:0] m_head_data;

    queue_access_t access_backlog[$];
    queue_answer_t awaited_answers[$];

    // Predicted queue contents
    bit [31:0]            model_tail;
    bit [31:0]            model_head;
    bit [STATUS_BITS-1:0] model_status[NUM_CELLS];
    bit [DATA_BITS-1:0]   model_element[NUM_CELLS];

    int            mismatches = 0;
    int            send_idle  = 0;
    int            recv_idle  = 0;
    bit            tail_phase = 1'b0;
    queue_access_t next_access;
    queue_answer_t seen_answer;
    queue_answer_t want_answer;

    lap_tagged_ring_queue i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_element_data (s_element_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_accepted     (m_accepted),
        .m_head_data    (m_head_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hold reset at start-up, then release it
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic bit [31:0] advance_index(bit [31:0] idx);
        bit [31:0] n;
        n = idx + 1;
        return (longint'(n) >= INDEX_RANGE) ? 32'd0 : n;
    endfunction

    // Apply one access to the predicted queue and queue the answer it gives
    function automatic void apply_access(logic [OP_BITS-1:0] op, logic [DATA_BITS-1:0] data);
        queue_answer_t        ans;
        int                   slot;
        bit [STATUS_BITS-1:0] lap;
        bit [31:0]            next_lap;
        ans.accepted  = 1'b0;
        ans.head_data = '0;
        if (op == OP_PUSH) begin
            slot = model_tail % NUM_CELLS;
            lap  = STATUS_BITS'(model_tail / NUM_CELLS);
            if (model_status[slot] == lap) begin
                model_element[slot] = data & ELEMENT_MASK;
                model_status[slot]  = lap | FULL_MARK;
                model_tail          = advance_index(model_tail);
                ans.accepted        = 1'b1;
            end
        end else if (op == OP_POP) begin
            slot = model_head % NUM_CELLS;
            lap  = STATUS_BITS'(model_head / NUM_CELLS);
            if (model_status[slot] == (lap | FULL_MARK)) begin
                next_lap = model_head / NUM_CELLS + 1;
                if (next_lap >= LAP_COUNT) begin
                    next_lap = 0;
                end
                model_status[slot] = STATUS_BITS'(next_lap) & ~FULL_MARK;
                model_head         = advance_index(model_head);
                ans.accepted       = 1'b1;
            end
        end else if (op == OP_PEEK) begin
            slot = model_head % NUM_CELLS;
            if ((model_status[slot] & FULL_MARK) != '0) begin
                ans.head_data = model_element[slot] & ELEMENT_MASK;
                ans.accepted  = 1'b1;
            end
        end
        awaited_answers.push_back(ans);
    endfunction

    task automatic report_mismatch(string what, logic [DATA_BITS-1:0] got,
                                   logic [DATA_BITS-1:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic add_access(logic [OP_BITS-1:0] op, logic [DATA_BITS-1:0] data);
        queue_access_t a;
        a.op   = op;
        a.data = data;
        access_backlog.push_back(a);
    endtask

    // Driver: predict each accepted transaction, then offer the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid        <= 1'b0;
            s_operation    <= OP_NONE;
            s_element_data <= '0;
            send_idle = 0;
        end else begin
            if (s_valid && s_ready) begin
                apply_access(s_operation, s_element_data);
            end
            if (!s_valid || s_ready) begin
                if (send_idle > 0) begin
                    send_idle--;
                    s_valid <= 1'b0;
                end else if (access_backlog.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (!(tail_phase && access_backlog.size() < QUIET_TAIL)
                             && $urandom_range(0, 9) == 0) begin
                    send_idle = $urandom_range(0, 14);
                    s_valid <= 1'b0;
                end else begin
                    next_access = access_backlog.pop_front();
                    s_valid        <= 1'b1;
                    s_operation    <= next_access.op;
                    s_element_data <= next_access.data;
                end
            end
        end
    end

    // Monitor: check each result transaction, stall the result side in bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_idle = 0;
        end else begin
            if (m_valid && m_ready) begin
                seen_answer.accepted  = m_accepted;
                seen_answer.head_data = m_head_data;
                if (awaited_answers.size() == 0) begin
                    report_mismatch("unexpected result", {63'd0, seen_answer.accepted},
                                    seen_answer.head_data);
                end else begin
                    want_answer = awaited_answers.pop_front();
                    if (seen_answer.accepted !== want_answer.accepted) begin
                        report_mismatch("accepted", {63'd0, seen_answer.accepted},
                                        {63'd0, want_answer.accepted});
                    end
                    if (seen_answer.head_data !== want_answer.head_data) begin
                        report_mismatch("head_data", seen_answer.head_data,
                                        want_answer.head_data);
                    end
                end
            end
            if (recv_idle > 0) begin
                recv_idle--;
                m_ready <= 1'b0;
            end else if (!(tail_phase && access_backlog.size() < QUIET_TAIL)
                         && $urandom_range(0, 9) == 0) begin
                recv_idle = $urandom_range(0, 14);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        int             count;
        int             run_mode;
        int             run_len;
        int             pick;
        logic [OP_BITS-1:0] op;

        model_tail = 0;
        model_head = 0;
        for (int i = 0; i < NUM_CELLS; i++) begin
            model_status[i]  = '0;
            model_element[i] = '0;
        end

        // Empty queue, spare code, fill to full, push on full, then read back
        add_access(OP_POP, '0);
        add_access(OP_PEEK, {DATA_BITS{1'b1}});
        add_access(OP_NONE, {DATA_BITS{1'b1}});
        add_access(OP_PUSH, '0);
        add_access(OP_PUSH, {DATA_BITS{1'b1}});
        add_access(OP_PUSH, 64'haaaa_aaaa_aaaa_aaaa);
        add_access(OP_PUSH, 64'h5555_5555_5555_5555);
        for (int i = 4; i < NUM_CELLS; i++) begin
            add_access(OP_PUSH, {$urandom, $urandom});
        end
        add_access(OP_PUSH, 64'h8000_0000_0000_0001);
        add_access(OP_PEEK, '0);
        add_access(OP_POP, '0);
        add_access(OP_PEEK, '0);
        add_access(OP_NONE, '0);

        // Let every directed access complete before the random part
        @(negedge aclk);
        while (access_backlog.size() != 0 || s_valid || awaited_answers.size() != 0) begin
            @(negedge aclk);
        end

        // Random runs biased towards filling, draining or a balanced mix
        count = 0;
        while (count < RANDOM_ACCESSES) begin
            run_mode = $urandom_range(RUN_FILL, RUN_BALANCE);
            run_len  = $urandom_range(8, 40);
            for (int k = 0; k < run_len && count < RANDOM_ACCESSES; k++) begin
                pick = $urandom_range(0, 99);
                case (run_mode)
                    RUN_FILL: begin
                        op = (pick < 70) ? OP_PUSH : (pick < 84) ? OP_POP :
                             (pick < 95) ? OP_PEEK : OP_NONE;
                    end
                    RUN_DRAIN: begin
                        op = (pick < 15) ? OP_PUSH : (pick < 65) ? OP_POP :
                             (pick < 95) ? OP_PEEK : OP_NONE;
                    end
                    default: begin
                        op = (pick < 40) ? OP_PUSH : (pick < 70) ? OP_POP :
                             (pick < 95) ? OP_PEEK : OP_NONE;
                    end
                endcase
                add_access(op, {$urandom, $urandom});
                count++;
            end
        end
        tail_phase = 1'b1;

        // Wait for every result and settle, then report the verdict
        while (access_backlog.size() != 0 || s_valid || awaited_answers.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Give up well past the slowest correct run
    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
